### hdl/deadline_timer_queue_macros.svh
// Assertion macros for the deadline timer queue.
`ifndef DEADLINE_TIMER_QUEUE_MACROS_SVH
`define DEADLINE_TIMER_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define DTQ_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deadline_timer_queue: check failed");
`define DTQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deadline_timer_queue: check failed");
`else
`define DTQ_ASSERT_IMPL(lbl, ante, cons)
`define DTQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hdl/dtq_pkg.sv
package dtq_pkg;

	localparam int DL_W = 64;
	localparam int ID_W = 4;

	localparam logic [1:0] REQ_SET    = 2'd0;
	localparam logic [1:0] REQ_CANCEL = 2'd1;
	localparam logic [1:0] REQ_TICK   = 2'd2;

	localparam logic [1:0] EV_FIRE    = 2'd0;
	localparam logic [1:0] EV_PROGRAM = 2'd1;
	localparam logic [1:0] EV_CLEAR   = 2'd2;
	localparam logic [1:0] EV_NONE    = 2'd3;

	typedef struct packed {
		logic            vld;
		logic [DL_W-1:0] dl;
		logic [ID_W-1:0] id;
	} slot_t;

	typedef struct packed {
		logic            ins_en;
		logic [DL_W-1:0] key_dl;
		logic [ID_W-1:0] key_id;
	} cell_ctl_t;

	localparam slot_t SLOT_EMPTY = '{vld: 1'b0, dl: '0, id: '0};

endpackage

### hdl/dtq_cell.sv
module dtq_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  dtq_pkg::cell_ctl_t ctl,
	input  logic              shl,
	input  logic              le_prev,
	input  dtq_pkg::slot_t    left,
	input  dtq_pkg::slot_t    right,
	output dtq_pkg::slot_t    slot,
	output logic              le,
	output logic              match
);
	import dtq_pkg::*;

	logic            vld_q;
	logic [DL_W-1:0] dl_q;
	logic [ID_W-1:0] id_q;

	assign slot  = '{vld: vld_q, dl: dl_q, id: id_q};
	assign le    = vld_q && (dl_q <= ctl.key_dl);
	assign match = vld_q && (id_q == ctl.key_id);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (shl) begin
			vld_q <= right.vld;
		end else if (ctl.ins_en && !le) begin
			vld_q <= le_prev ? 1'b1 : left.vld;
		end
	end

	// advance toward the head, or open a gap for the new entry
	always_ff @(posedge clk) begin
		if (shl) begin
			dl_q <= right.dl;
			id_q <= right.id;
		end else if (ctl.ins_en && !le) begin
			if (le_prev) begin
				dl_q <= ctl.key_dl;
				id_q <= ctl.key_id;
			end else begin
				dl_q <= left.dl;
				id_q <= left.id;
			end
		end
	end

endmodule

### hdl/deadline_timer_queue.sv
// Channel  | Direction | Handshake            | Payload
// request  | in        | start, busy          | req_type, timer_id, deadline, now
// result   | out       | strobe (one cycle)   | event_kind, fired_id, next_deadline, last
//
// A set, or a cancel of an armed timer, steps as follows from accept to the next
// accept: close the gap across the cell row, insert or read the new head, then idle.
// The timer id is matched across the row at the accept edge. A cancel of an unarmed
// timer closes no gap and goes back to idle, and an undefined request is answered from
// idle. A tick fires each expired timer in turn, as the row shifts once per fire beat.
// Reset clears the valid bit of every cell. Results cannot be stalled.
module deadline_timer_queue #(
	parameter int TIMER_COUNT = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                req_type,
	input  logic [dtq_pkg::ID_W-1:0]  timer_id,
	input  logic [dtq_pkg::DL_W-1:0]  deadline,
	input  logic [dtq_pkg::DL_W-1:0]  now,
	output logic                      strobe,
	output logic [1:0]                event_kind,
	output logic [dtq_pkg::ID_W-1:0]  fired_id,
	output logic [dtq_pkg::DL_W-1:0]  next_deadline,
	output logic                      last
);
	import dtq_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DROP   = 5'b00010,
		ST_INSERT = 5'b00100,
		ST_HEAD   = 5'b01000,
		ST_POP    = 5'b10000
	} state_t;

	state_t                 state_q, state_d;
	logic [1:0]             req_q;
	logic [ID_W-1:0]        id_q;
	logic [DL_W-1:0]        val_q;
	logic [TIMER_COUNT-1:0] match_q;

	slot_t                  slots [TIMER_COUNT];
	logic [TIMER_COUNT-1:0] le, match, gone, shl, vld;
	cell_ctl_t              ctl;

	logic            accept, id_ok, found, full, pop_now;
	logic            res_vld, res_last;
	logic [1:0]      res_kind;
	logic [ID_W-1:0] res_id;
	logic [DL_W-1:0] res_dl;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign id_ok   = ({28'd0, timer_id} < 32'(TIMER_COUNT));
	assign found   = |match_q;
	assign full    = slots[TIMER_COUNT-1].vld;
	assign pop_now = slots[0].vld && (slots[0].dl <= val_q);

	assign ctl.key_id = (state_q == ST_IDLE) ? timer_id : id_q;
	assign ctl.key_dl = val_q;
	assign ctl.ins_en = (state_q == ST_INSERT) && !full;

	for (genvar g = 0; g < TIMER_COUNT; g++) begin : g_cell
		slot_t left_s, right_s;
		logic  le_prev;

		if (g == 0) begin : g_head
			assign left_s  = SLOT_EMPTY;
			assign le_prev = 1'b1;
		end else begin : g_mid
			assign left_s  = slots[g-1];
			assign le_prev = le[g-1];
		end
		if (g == TIMER_COUNT - 1) begin : g_tail
			assign right_s = SLOT_EMPTY;
		end else begin : g_body
			assign right_s = slots[g+1];
		end

		assign gone[g] = |match_q[g:0];
		assign shl[g]  = ((state_q == ST_DROP) && gone[g]) || ((state_q == ST_POP) && pop_now);
		assign vld[g]  = slots[g].vld;

		dtq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.shl     (shl[g]),
			.le_prev (le_prev),
			.left    (left_s),
			.right   (right_s),
			.slot    (slots[g]),
			.le      (le[g]),
			.match   (match[g])
		);
	end

	always_comb begin
		state_d  = state_q;
		res_vld  = 1'b0;
		res_kind = EV_NONE;
		res_id   = '0;
		res_dl   = '0;
		res_last = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if ((req_type inside {REQ_SET, REQ_CANCEL}) && id_ok) begin
						state_d = ST_DROP;
					end else if (req_type == REQ_TICK) begin
						state_d = ST_POP;
					end else begin
						res_vld = 1'b1;
					end
				end
			end
			ST_DROP: begin
				if (req_q == REQ_SET) begin
					state_d = ST_INSERT;
				end else if (found) begin
					state_d = ST_HEAD;
				end else begin
					state_d = ST_IDLE;
					res_vld = 1'b1;
				end
			end
			ST_INSERT: begin
				state_d = ST_IDLE;
				res_vld = 1'b1;
				if (!full && !le[0]) begin
					res_kind = EV_PROGRAM;
					res_dl   = val_q;
				end
			end
			ST_HEAD, ST_POP: begin
				res_vld = 1'b1;
				if (state_q == ST_POP && pop_now) begin
					res_kind = EV_FIRE;
					res_id   = slots[0].id;
					res_last = 1'b0;
				end else begin
					state_d = ST_IDLE;
					if (slots[0].vld) begin
						res_kind = EV_PROGRAM;
						res_dl   = slots[0].dl;
					end else begin
						res_kind = EV_CLEAR;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			strobe  <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe  <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req_type;
			id_q    <= timer_id;
			val_q   <= (req_type == REQ_TICK) ? now : deadline;
			match_q <= match;
		end
		event_kind    <= res_kind;
		fired_id      <= res_id;
		next_deadline <= res_dl;
		last          <= res_last;
	end

	`include "deadline_timer_queue_macros.svh"

	`DTQ_ASSERT_IMPL(a_more_beats_busy, strobe && !last, busy)
	`DTQ_ASSERT_IMPL(a_cells_packed, 1'b1, ((vld >> 1) & ~vld) == '0)
	`DTQ_ASSERT_IMPL(a_fire_not_last, strobe && event_kind == EV_FIRE, !last)
	`DTQ_ASSERT_NEXT(a_tick_pops, accept && req_type == REQ_TICK, state_q == ST_POP)

endmodule
